// ===== sv/tsp_pkg.sv =====
// Package for the timed sample packetizer: payload structs, register indexes,
// result kind codes and sizing constants. No dependencies.
package tsp_pkg;

    localparam int MAX_PACKET_BYTES  = 65536;
    localparam int MAX_BLOCK_SAMPLES = 256;
    localparam int SAMPLE_BYTES      = 4;
    localparam int CAP_TOP           = MAX_PACKET_BYTES / SAMPLE_BYTES;

    // results one input can cause, and depth of the result queue
    localparam int RES_MAX = 3;
    localparam int QDEPTH  = 16;
    localparam int QCW     = $clog2(QDEPTH + 1);

    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] FMT_UNCOMPRESSED = 2'd0;

    localparam logic [7:0] REG_MAX_BYTES    = 8'd0;
    localparam logic [7:0] REG_INTERVAL     = 8'd1;
    localparam logic [7:0] REG_FORMAT       = 8'd2;
    localparam logic [7:0] REG_EMIT_ENABLED = 8'd3;

    localparam logic [16:0] RST_MAX_BYTES = 17'd4096;
    localparam logic [31:0] RST_INTERVAL  = 32'd10000000;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [63:0]        block_time_ns;
        logic               first_in_block;
        logic [7:0]         index_in_block;
        logic [7:0]         quality;
        logic [31:0]        sequence_number;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] stored_sample;
        logic [13:0]        slot;
        logic [63:0]        packet_start_ns;
        logic [14:0]        packet_samples;
        logic [7:0]         packet_quality;
        logic [31:0]        packet_sequence;
        logic [7:0]         start_offset;
        logic signed [63:0] tear_ns;
        logic               delivered;
        logic               last;
    } t_out;

endpackage

// ===== sv/timed_sample_packetizer.sv =====
// An accepted request moves through the pipeline registers into the result queue.
// One request per cycle while each gives one result and i_stall is low; the output
// port moves one result per cycle; a packet-closing request gives 2 or 3 results.
// The input stalls when the 16-entry result queue cannot cover everything in flight.
// Reset (synchronous, active low): registers to defaults, packet state zero, empty.
module timed_sample_packetizer import tsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in         i_data,
    output logic        o_stall,
    output logic        o_valid,
    output t_out        o_data,
    input  logic        i_stall,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_cfg_ready
);

    localparam int IDX_TAB = 256;

    // configuration
    logic [16:0] r_max_bytes;
    logic [31:0] r_interval;
    logic [1:0]  r_format;
    logic        r_emit;

    // pipeline
    logic        r_v1, r_v2, r_v3;
    t_in         r_s1, r_s2, r_s3;
    logic [7:0]  r_s2_idx, r_s3_idx;
    logic [39:0] r_s2_prod;
    logic [63:0] r_s3_st, r_s3_stp;

    // packet state
    logic [14:0] r_count, n_count;
    logic [63:0] r_last, n_last;
    logic [63:0] r_expect, n_expect;
    logic [63:0] r_start, n_start;
    logic [7:0]  r_hq, n_hq;
    logic [31:0] r_hs, n_hs;
    logic [7:0]  r_ho, n_ho;

    logic [7:0]     w_idx_mod [IDX_TAB];
    logic [14:0]    w_cap;
    logic [63:0]    w_up, w_tear, w_mag;
    logic           w_early, w_hit, w_new, w_full, w_fmt_ok;
    logic [14:0]    w_cnt_eff, w_cnt_new;
    t_out           w_rec_tear, w_rec_store, w_rec_close;
    t_out           w_res [RES_MAX];
    logic [1:0]     w_nres;
    logic [1:0]     w_push_cnt;
    logic [QCW-1:0] w_q_count;
    logic [5:0]     w_resv;
    logic           w_pop;

    for (genvar g = 0; g < IDX_TAB; g++) begin : g_idx
        assign w_idx_mod[g] = 8'(g % MAX_BLOCK_SAMPLES);
    end

    // capacity in samples, clamped to 1..CAP_TOP
    always_comb begin
        w_cap = r_max_bytes[16:2];
        if (w_cap == 15'd0) begin
            w_cap = 15'd1;
        end else if (w_cap > 15'(CAP_TOP)) begin
            w_cap = 15'(CAP_TOP);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= RST_MAX_BYTES;
            r_interval  <= RST_INTERVAL;
            r_format    <= FMT_UNCOMPRESSED;
            r_emit      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MAX_BYTES:    r_max_bytes <= i_cfg_data[16:0];
                REG_INTERVAL:     r_interval  <= i_cfg_data;
                REG_FORMAT:       r_format    <= i_cfg_data[1:0];
                REG_EMIT_ENABLED: r_emit      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // every request in flight may need three queue entries
    assign w_resv = 6'(w_q_count) + 6'(RES_MAX) * (6'(r_v1) + 6'(r_v2) + 6'(r_v3))
                  + 6'(RES_MAX);
    assign o_stall = w_resv > 6'(QDEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid && !o_stall;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // start time terms: index times interval, then block time plus that, and plus one interval more
    always_ff @(posedge i_clk) begin
        r_s1      <= i_data;
        r_s2      <= r_s1;
        r_s2_idx  <= w_idx_mod[r_s1.index_in_block];
        r_s2_prod <= 40'(w_idx_mod[r_s1.index_in_block]) * 40'(r_interval);
        r_s3      <= r_s2;
        r_s3_idx  <= r_s2_idx;
        r_s3_st   <= r_s2.block_time_ns + 64'(r_s2_prod);
        r_s3_stp  <= r_s2.block_time_ns + 64'(r_s2_prod) + 64'(r_interval);
    end

    // final stage: format check, tear check, store, full check
    always_comb begin
        w_fmt_ok  = r_format == FMT_UNCOMPRESSED;
        w_up      = r_expect - r_s3.block_time_ns;
        w_tear    = r_s3.block_time_ns - r_expect;
        w_early   = r_s3.block_time_ns < r_expect;
        w_mag     = w_early ? w_up : w_tear;
        w_hit     = r_s3.first_in_block && r_count != 15'd0 && w_mag != 64'd0
                 && w_mag >= 64'(r_interval);
        w_cnt_eff = w_hit ? 15'd0 : r_count;
        w_new     = w_cnt_eff == 15'd0;
        w_cnt_new = w_cnt_eff + 15'd1;
        w_full    = w_cnt_new >= w_cap;

        n_start  = w_new ? r_s3_st : r_start;
        n_hq     = w_new ? r_s3.quality : r_hq;
        n_hs     = w_new ? r_s3.sequence_number : r_hs;
        n_ho     = w_new ? r_s3_idx : r_ho;
        n_last   = w_new ? r_s3_st : r_expect;
        n_expect = w_new ? r_s3_stp : r_expect + 64'(r_interval);
        n_count  = w_full ? 15'd0 : w_cnt_new;

        w_rec_tear                 = '0;
        w_rec_tear.kind            = KIND_CLOSE;
        w_rec_tear.packet_start_ns = r_start;
        w_rec_tear.packet_samples  = r_count;
        w_rec_tear.packet_quality  = r_hq;
        w_rec_tear.packet_sequence = r_hs;
        w_rec_tear.start_offset    = r_ho;
        w_rec_tear.tear_ns         = w_tear;
        w_rec_tear.delivered       = r_emit;

        w_rec_store                 = '0;
        w_rec_store.kind            = KIND_STORE;
        w_rec_store.stored_sample   = r_s3.sample_value;
        w_rec_store.slot            = w_cnt_eff[13:0];
        w_rec_store.packet_start_ns = n_start;
        w_rec_store.packet_samples  = w_cnt_new;
        w_rec_store.packet_quality  = n_hq;
        w_rec_store.packet_sequence = n_hs;
        w_rec_store.start_offset    = n_ho;
        w_rec_store.last            = !w_full;

        w_rec_close           = w_rec_store;
        w_rec_close.kind      = KIND_CLOSE;
        w_rec_close.stored_sample = '0;
        w_rec_close.slot      = '0;
        w_rec_close.delivered = r_emit;
        w_rec_close.last      = 1'b1;

        for (int k = 0; k < RES_MAX; k++) begin
            w_res[k] = w_rec_close;
        end
        if (!w_fmt_ok) begin
            w_res[0]      = '0;
            w_res[0].kind = KIND_ERROR;
            w_res[0].last = 1'b1;
            w_nres        = 2'd1;
        end else if (w_hit) begin
            w_res[0] = w_rec_tear;
            w_res[1] = w_rec_store;
            w_nres   = w_full ? 2'd3 : 2'd2;
        end else begin
            w_res[0] = w_rec_store;
            w_nres   = w_full ? 2'd2 : 2'd1;
        end
        w_push_cnt = r_v3 ? w_nres : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_last   <= '0;
            r_expect <= '0;
            r_start  <= '0;
            r_hq     <= '0;
            r_hs     <= '0;
            r_ho     <= '0;
        end else if (r_v3) begin
            if (w_fmt_ok) begin
                r_count  <= n_count;
                r_last   <= n_last;
                r_expect <= n_expect;
                r_start  <= n_start;
                r_hq     <= n_hq;
                r_hs     <= n_hs;
                r_ho     <= n_ho;
            end
        end else begin
            // keep the expected time in step with an interval rewritten while idle
            r_expect <= r_last + 64'(r_interval);
        end
    end

    assign w_pop = o_valid && !i_stall;

    tsp_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop      (w_pop),
        .i_push_cnt (w_push_cnt),
        .i_res      (w_res),
        .o_head     (o_data),
        .o_count    (w_q_count)
    );

    assign o_valid = w_q_count != '0;

endmodule

// ===== sv/tsp_result_queue.sv =====
// Result queue: shift queue with the head at entry 0, up to three pushes a cycle.
// Depends on tsp_pkg.
module tsp_result_queue import tsp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop,
    input  logic [1:0]     i_push_cnt,
    input  t_out           i_res [RES_MAX],
    output t_out           o_head,
    output logic [QCW-1:0] o_count
);

    t_out           r_q [QDEPTH];
    t_out           n_q [QDEPTH];
    logic [QCW-1:0] r_count;
    logic [QCW-1:0] n_count;
    logic [QCW-1:0] w_base;

    always_comb begin
        w_base  = r_count - QCW'(i_pop);
        n_count = w_base + QCW'(i_push_cnt);
        for (int i = 0; i < QDEPTH; i++) begin
            n_q[i] = r_q[i];
            if (i_pop && i < QDEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end
            for (int k = 0; k < RES_MAX; k++) begin
                if (k < int'(i_push_cnt) && int'(w_base) + k == i) begin
                    n_q[i] = i_res[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_head  = r_q[0];
    assign o_count = r_count;

endmodule

// ===== sv/tsp_checker.sv =====
// Port-level checker for the timed sample packetizer, bound to the top level.
// Depends on tsp_pkg.
module tsp_checker import tsp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input t_out o_data,
    input logic i_stall
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("stalled result changed");

    a_slot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_STORE
        |-> o_data.packet_samples == {1'b0, o_data.slot} + 15'd1)
        else $error("stored sample count does not follow slot");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_ERROR |-> o_data.last && !o_data.delivered)
        else $error("format error result not a lone result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind timed_sample_packetizer tsp_checker u_tsp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for timed_sample_packetizer: directed and random sample
// streams, a request-level packet predictor, and field-by-field result checking.
// Depends on tsp_pkg and timed_sample_packetizer.
module tb;
    import tsp_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    t_in         i_data      = '0;
    logic        o_stall;
    logic        o_valid;
    t_out        o_data;
    logic        i_stall     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        o_cfg_ready;

    timed_sample_packetizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [16:0] cfg_max_bytes = RST_MAX_BYTES;
    logic [31:0] cfg_interval  = RST_INTERVAL;
    logic [1:0]  cfg_format    = FMT_UNCOMPRESSED;
    logic        cfg_emit      = 1'b0;

    // predictor copy of the open packet
    logic [14:0] pk_count   = '0;
    logic [63:0] pk_last    = '0;
    logic [63:0] pk_start   = '0;
    logic [7:0]  pk_quality = '0;
    logic [31:0] pk_seq     = '0;
    logic [7:0]  pk_offset  = '0;

    t_in  sample_backlog[$];
    t_out due_results[$];
    t_out want;
    int   n_errors = 0;

    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    bit   tx_hold;
    int   tx_gap = 0;
    int   rx_wait = 0;
    int   hold_left = 0;
    int   hold_asks = 0;
    int   hold_served = 0;
    logic [63:0] st_time = '0;

    function automatic t_out packet_fields(input logic [1:0] kind, input logic [31:0] smp,
                                           input logic [13:0] slot, input logic [14:0] cnt,
                                           input logic [63:0] tear, input logic deliv);
        t_out r;
        r = '0;
        r.kind            = kind;
        r.stored_sample   = smp;
        r.slot            = slot;
        r.packet_start_ns = pk_start;
        r.packet_samples  = cnt;
        r.packet_quality  = pk_quality;
        r.packet_sequence = pk_seq;
        r.start_offset    = pk_offset;
        r.tear_ns         = tear;
        r.delivered       = deliv;
        return r;
    endfunction

    // Work out the results of one accepted request and queue them.
    function automatic void packetize_sample(input t_in req);
        t_out        r;
        logic [63:0] ival;
        logic [63:0] due;
        logic [63:0] mag;
        logic        early;
        logic [13:0] slot;
        int unsigned cap;
        ival = {32'd0, cfg_interval};
        if (cfg_format != FMT_UNCOMPRESSED) begin
            r = '0;
            r.kind = KIND_ERROR;
            due_results.push_back(r);
        end else begin
            if (req.first_in_block && pk_count != 0) begin
                due = pk_last + ival;
                mag = '0;
                early = 1'b0;
                if (req.block_time_ns < due) begin
                    mag = due - req.block_time_ns;
                    early = 1'b1;
                end else if (req.block_time_ns > due) begin
                    mag = req.block_time_ns - due;
                end
                if (mag < ival) mag = '0;
                if (mag != 0) begin
                    due_results.push_back(packet_fields(KIND_CLOSE, '0, '0, pk_count,
                                                        early ? 64'd0 - mag : mag, cfg_emit));
                    pk_count = '0;
                end
            end
            if (pk_count == 0) begin
                pk_start   = req.block_time_ns + {56'd0, req.index_in_block} * ival;
                pk_last    = pk_start - ival;
                pk_quality = req.quality;
                pk_seq     = req.sequence_number;
                pk_offset  = req.index_in_block;
            end
            slot = pk_count[13:0];
            pk_count = pk_count + 15'd1;
            pk_last = pk_last + ival;
            due_results.push_back(packet_fields(KIND_STORE, req.sample_value, slot, pk_count,
                                                '0, 1'b0));
            cap = cfg_max_bytes / SAMPLE_BYTES;
            if (cap < 1) cap = 1;
            if (cap > CAP_TOP) cap = CAP_TOP;
            if (pk_count >= cap) begin
                due_results.push_back(packet_fields(KIND_CLOSE, '0, '0, pk_count, '0, cfg_emit));
                pk_count = '0;
            end
        end
        r = due_results.pop_back();
        r.last = 1'b1;
        due_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, got_v);
            n_errors++;
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            tx_hold = i_valid;
            if (i_valid && !o_stall) begin
                packetize_sample(i_data);
                tx_hold = 1'b0;
                tx_gap = tx_idle ? $urandom_range(3, 0) : 0;
            end
            if (!tx_hold) begin
                if (tx_gap > 0) begin
                    tx_gap = tx_gap - 1;
                end else if (sample_backlog.size() != 0) begin
                    i_data <= sample_backlog.pop_front();
                    tx_hold = 1'b1;
                end
            end
            i_valid <= tx_hold;
        end
    end

    // long receiver hold-off, started on request from the stimulus
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asks) begin
            hold_left <= 300;
            hold_served <= hold_served + 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none actual %h", $time, o_data);
                    n_errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, o_data.kind);
                    check_field("stored_sample", want.stored_sample, o_data.stored_sample);
                    check_field("slot", want.slot, o_data.slot);
                    check_field("packet_start_ns", want.packet_start_ns,
                                o_data.packet_start_ns);
                    check_field("packet_samples", want.packet_samples, o_data.packet_samples);
                    check_field("packet_quality", want.packet_quality, o_data.packet_quality);
                    check_field("packet_sequence", want.packet_sequence,
                                o_data.packet_sequence);
                    check_field("start_offset", want.start_offset, o_data.start_offset);
                    check_field("tear_ns", want.tear_ns, o_data.tear_ns);
                    check_field("delivered", want.delivered, o_data.delivered);
                    check_field("last", want.last, o_data.last);
                end
                rx_wait = rx_idle ? $urandom_range(3, 0) : 0;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            i_stall <= (rx_wait > 0) || (hold_left > 0);
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MAX_BYTES:    cfg_max_bytes = val[16:0];
            REG_INTERVAL:     cfg_interval  = val;
            REG_FORMAT:       cfg_format    = val[1:0];
            REG_EMIT_ENABLED: cfg_emit      = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_req(input logic [31:0] smp, input logic [63:0] bt, input logic fst,
                            input logic [7:0] ix, input logic [7:0] q, input logic [31:0] sq);
        t_in r;
        r.sample_value    = smp;
        r.block_time_ns   = bt;
        r.first_in_block  = fst;
        r.index_in_block  = ix;
        r.quality         = q;
        r.sequence_number = sq;
        sample_backlog.push_back(r);
    endtask

    // wait until the sender is drained and every expected result has arrived
    task automatic settle();
        do @(negedge i_clk);
        while (sample_backlog.size() != 0 || i_valid || due_results.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // Mostly well-formed time-stamped blocks, with tears, jitter and some noise.
    task automatic gen_blocks(input int n_items);
        int          left;
        int          len;
        int          k;
        logic [63:0] ival;
        logic [63:0] bt;
        logic [63:0] jit;
        logic [7:0]  ix0;
        logic [7:0]  q;
        logic [31:0] sq;
        logic [31:0] smp;
        left = n_items;
        ival = {32'd0, cfg_interval};
        while (left > 0) begin
            if ($urandom_range(99, 0) < 8) begin
                push_req($urandom, {$urandom, $urandom}, $urandom_range(1, 0),
                         $urandom_range(255, 0), $urandom_range(255, 0), $urandom);
                left--;
            end else begin
                len = $urandom_range(12, 1);
                ix0 = ($urandom_range(9, 0) == 0) ? $urandom_range(255, 0) : 8'd0;
                q   = $urandom_range(255, 0);
                sq  = $urandom;
                jit = (cfg_interval > 1) ? {32'd0, $urandom_range(cfg_interval - 1, 0)} : '0;
                case ($urandom_range(9, 0))
                    0: bt = st_time - {61'd0, 3'($urandom_range(4, 1))} * ival - jit;
                    1: bt = st_time + {61'd0, 3'($urandom_range(4, 1))} * ival + jit;
                    2: bt = st_time + jit;
                    3: bt = st_time - jit;
                    4: bt = {$urandom, $urandom};
                    default: bt = st_time;
                endcase
                for (k = 0; k < len && left > 0; k++) begin
                    case ($urandom_range(7, 0))
                        0: smp = 32'h7FFF_FFFF;
                        1: smp = 32'h8000_0000;
                        default: smp = $urandom;
                    endcase
                    push_req(smp, bt, k == 0, ix0 + 8'(k), q, sq);
                    left--;
                end
                st_time = bt + 64'(k) * ival;
            end
        end
    endtask

    task automatic run_phase(input logic [16:0] mb, input logic [31:0] iv,
                             input logic [1:0] fmt, input logic en, input int n_items,
                             input bit tx_i, input bit rx_i);
        write_reg(REG_MAX_BYTES, {15'd0, mb});
        write_reg(REG_INTERVAL, iv);
        write_reg(REG_FORMAT, {30'd0, fmt});
        write_reg(REG_EMIT_ENABLED, {31'd0, en});
        @(negedge i_clk);
        tx_idle = tx_i;
        rx_idle = rx_i;
        gen_blocks(n_items);
        settle();
    endtask

    initial begin
        logic [63:0] t0;
        logic [63:0] iv;
        logic [63:0] tb_t;
        logic [63:0] wrap_t;
        logic [16:0] mb;
        logic [31:0] ivr;
        int          p;
        t0 = 64'd1000;
        iv = 64'd10000000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // continuity, early and late tears, jitter just under one interval
        push_req(32'h7FFF_FFFF, t0, 1'b1, 8'd0, 8'hFF, 32'hFFFF_FFFF);
        push_req(32'h8000_0000, t0, 1'b0, 8'd1, 8'hFF, 32'hFFFF_FFFF);
        push_req(32'h0000_1234, t0 + 2 * iv, 1'b1, 8'd0, 8'h00, 32'h0);
        push_req(32'hFFFF_FFFF, t0 + iv, 1'b1, 8'd0, 8'h5A, 32'h1);
        push_req(32'h0000_0001, t0 + 3 * iv, 1'b1, 8'd0, 8'hA5, 32'h2);
        push_req(32'h0000_0002, t0 + 5 * iv - 1, 1'b1, 8'd0, 8'h11, 32'h3);
        push_req(32'h0000_0003, t0 + 4 * iv + 1, 1'b1, 8'd0, 8'h22, 32'h4);
        settle();

        // capacity below one sample while a packet is open: tear, store and full close
        write_reg(REG_MAX_BYTES, 32'd3);
        write_reg(REG_EMIT_ENABLED, 32'd1);
        @(negedge i_clk);
        push_req(32'h0000_0004, t0 + 11 * iv, 1'b1, 8'd0, 8'h33, 32'h5);
        push_req(32'h0000_0005, t0, 1'b0, 8'd7, 8'h44, 32'h6);
        settle();

        // zero interval: only an exact match is continuous; capacity above the top
        write_reg(REG_MAX_BYTES, 32'd131071);
        write_reg(REG_INTERVAL, 32'd0);
        @(negedge i_clk);
        tb_t = 64'h0123_4567_89AB_CDEF;
        push_req(32'h0000_0006, tb_t, 1'b1, 8'd200, 8'h00, 32'h0);
        push_req(32'h0000_0007, tb_t, 1'b0, 8'd201, 8'h00, 32'h0);
        push_req(32'h0000_0008, tb_t, 1'b1, 8'd0, 8'h01, 32'h7);
        push_req(32'h0000_0009, tb_t + 1, 1'b1, 8'd0, 8'h02, 32'h8);
        push_req(32'h0000_000A, tb_t, 1'b1, 8'd0, 8'h03, 32'h9);
        settle();

        // widest interval and start times that wrap past 2^64
        write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
        write_reg(REG_MAX_BYTES, 32'd65536);
        @(negedge i_clk);
        wrap_t = 64'hFFFF_FFFF_FFFF_FF9C;
        push_req(32'h0000_000B, wrap_t, 1'b1, 8'd255, 8'h80, 32'h8000_0000);
        push_req(32'h0000_000C, wrap_t, 1'b0, 8'd0, 8'h80, 32'h8000_0000);
        push_req(32'h0000_000D, wrap_t + 64'd257 * 64'hFFFF_FFFF, 1'b1, 8'd0, 8'h7F,
                 32'h7FFF_FFFF);
        settle();

        // unsupported formats
        write_reg(REG_FORMAT, 32'd1);
        @(negedge i_clk);
        push_req(32'h0, 64'h0, 1'b0, 8'd0, 8'd0, 32'h0);
        settle();
        write_reg(REG_FORMAT, 32'd2);
        @(negedge i_clk);
        push_req(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd255, 8'hFF, 32'hFFFF_FFFF);
        settle();
        write_reg(REG_FORMAT, 32'd3);
        @(negedge i_clk);
        push_req($urandom, {$urandom, $urandom}, 1'b1, 8'd9, 8'd9, $urandom);
        settle();

        // back to uncompressed, tossed single-sample packets
        write_reg(REG_FORMAT, {30'd0, FMT_UNCOMPRESSED});
        write_reg(REG_EMIT_ENABLED, 32'd0);
        write_reg(REG_MAX_BYTES, 32'd4);
        write_reg(REG_INTERVAL, 32'd10000000);
        @(negedge i_clk);
        push_req(32'h0000_0000, 64'd5, 1'b1, 8'd0, 8'h10, 32'h10);
        push_req(32'h8000_0001, 64'd5, 1'b0, 8'd1, 8'h10, 32'h10);
        settle();

        // random streams
        st_time = {$urandom, $urandom};
        run_phase(17'd16, 32'd10000000, FMT_UNCOMPRESSED, 1'b1, 60, 1'b1, 1'b1);

        // receiver holds off while the sender keeps offering: the result queue fills
        write_reg(REG_MAX_BYTES, 32'd40);
        write_reg(REG_INTERVAL, $urandom_range(100000, 1));
        write_reg(REG_EMIT_ENABLED, 32'd0);
        @(negedge i_clk);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        hold_asks++;
        gen_blocks(120);
        settle();

        st_time = 64'hFFFF_FFFF_FFFF_F000;
        run_phase($urandom_range(100, 0), 32'd1, FMT_UNCOMPRESSED, 1'b1, 60, 1'b0, 1'b0);
        run_phase(17'd65536, 32'hFFFF_FFFF, FMT_UNCOMPRESSED, $urandom_range(1, 0), 40,
                  1'b1, 1'b0);

        // capacity lowered under an open packet
        run_phase(17'd400, 32'd1000, FMT_UNCOMPRESSED, 1'b1, 30, 1'b0, 1'b1);
        run_phase(17'd12, 32'd1000, FMT_UNCOMPRESSED, 1'b1, 30, 1'b1, 1'b1);

        for (p = 0; p < 5; p++) begin
            case ($urandom_range(5, 0))
                0: mb = 17'd0;
                1: mb = 17'd131071;
                default: mb = $urandom_range(64, 4);
            endcase
            case ($urandom_range(5, 0))
                0: ivr = 32'd0;
                1: ivr = 32'd1;
                2: ivr = 32'hFFFF_FFFF;
                3: ivr = $urandom;
                default: ivr = $urandom_range(1000, 2);
            endcase
            run_phase(mb, ivr,
                      ($urandom_range(5, 0) < 4) ? FMT_UNCOMPRESSED : 2'($urandom_range(3, 1)),
                      $urandom_range(1, 0), 20, $urandom_range(1, 0), $urandom_range(1, 0));
        end

        repeat (20) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
